[rtl/dbcm_pkg.sv]
// ----------------------------------------------------------------------------
// dbcm_pkg
// Shared constants, codes and controller/datapath interface types for the
// DMA buffer chain manager.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcm_pkg;

  localparam int BUF_COUNT = 8;
  localparam int DATA_SIZE = 4096;

  localparam int IDX_W     = $clog2(BUF_COUNT);
  localparam int PTR_W     = $clog2(BUF_COUNT + 1);
  localparam int LEN_W     = $clog2(DATA_SIZE + 1);
  localparam int CAP_BYTES = BUF_COUNT * DATA_SIZE;
  localparam int USED_W    = $clog2(CAP_BYTES + 1);
  localparam int STORE_D   = BUF_COUNT * DATA_SIZE;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(BUF_COUNT);

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_FLUSH = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_QUEUED  = 2'd2;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_PUSH,
    DP_POOL_RESET,
    DP_NOP_RESULT,
    DP_SEARCH,
    DP_FREE_ACT,
    DP_ACT_FIN,
    DP_FREE_END,
    DP_IDLE_FIN
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       active;
    logic       found;
    logic       search_over;
    logic       act_done;
    logic       end_cond;
    logic       end_done;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/dma_buffer_chain_manager.sv]
// Push, pool reset and unknown requests give their result after the latch
// and decode steps; a flush additionally searches or frees the chain link
// by link with the shared link walker. Transactions are taken one at a
// time: a new one only while idle and with no result left for the sink.
// Reset (rst_n low, synchronous) empties the pool with buffer 0 filling.
// ----------------------------------------------------------------------------
// dma_buffer_chain_manager
// Buffer pool manager that fills DMA buffers byte by byte, chains full
// buffers into a descriptor queue, and frees or restarts them on flush.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_buffer_chain_manager
  import dbcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [8] dma_active, [9] dma_end, [10] cur_cb_valid,
  // [13:11] cur_cb_index, [15:14] zero
  input  wire logic [15:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] accepted, [1] start_dma, [4:2] start_index, [20:5] avail_bytes,
  // [23:21] zero
  output logic [23:0]      out_tdata
);

  // The controller sequences each transaction; the datapath holds the
  // buffer table and chain pointers and reports the walk conditions back.
  dp_cmd_t    cmd;
  dp_status_t st;

  logic        res_accepted;
  logic        res_start_dma;
  logic [2:0]  res_start_index;
  logic [15:0] res_avail_bytes;

  dbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd)
  );

  dbcm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_tuser),
    .in_data_byte    (in_tdata[7:0]),
    .in_dma_active   (in_tdata[8]),
    .in_dma_end      (in_tdata[9]),
    .in_cur_cb_valid (in_tdata[10]),
    .in_cur_cb_index (in_tdata[13:11]),
    .st              (st),
    .res_accepted    (res_accepted),
    .res_start_dma   (res_start_dma),
    .res_start_index (res_start_index),
    .res_avail_bytes (res_avail_bytes)
  );

  // The result registers only change while a transaction is being worked on,
  // so they stay put while a finished result waits for the sink.
  assign out_tdata = {3'b000, res_avail_bytes, res_start_index, res_start_dma,
                      res_accepted};

endmodule

`default_nettype wire

[rtl/dbcm_ram.sv]
// ----------------------------------------------------------------------------
// dbcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/dbcm_ctrl.sv]
// ----------------------------------------------------------------------------
// dbcm_ctrl
// Sequencer: accepts a transaction, steps the datapath through the chain walk
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_ctrl
  import dbcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_FREE_ACT,
    S_FREE_END
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   done;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NONE;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd       = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.req)
          REQ_PUSH: begin
            cmd  = DP_PUSH;
            done = 1'b1;
          end
          REQ_RESET: begin
            cmd  = DP_POOL_RESET;
            done = 1'b1;
          end
          REQ_FLUSH: begin
            if (st.active) begin
              state_nxt = S_SEARCH;
            end else if (st.end_cond) begin
              state_nxt = S_FREE_END;
            end else begin
              cmd  = DP_IDLE_FIN;
              done = 1'b1;
            end
          end
          default: begin
            cmd  = DP_NOP_RESULT;
            done = 1'b1;
          end
        endcase
      end
      S_SEARCH: begin
        if (st.found) begin
          state_nxt = S_FREE_ACT;
        end else if (st.search_over) begin
          cmd  = DP_NOP_RESULT;
          done = 1'b1;
        end else begin
          cmd = DP_SEARCH;
        end
      end
      S_FREE_ACT: begin
        if (st.act_done) begin
          cmd  = DP_ACT_FIN;
          done = 1'b1;
        end else begin
          cmd = DP_FREE_ACT;
        end
      end
      S_FREE_END: begin
        if (st.end_done) begin
          cmd  = DP_IDLE_FIN;
          done = 1'b1;
        end else begin
          cmd = DP_FREE_END;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (done) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt = done ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/dbcm_dp.sv]
// ----------------------------------------------------------------------------
// dbcm_dp
// Datapath: buffer table, chain pointers, byte counter, result registers and
// the byte store.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_dp
  import dbcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_dma_active,
  input  wire logic        in_dma_end,
  input  wire logic        in_cur_cb_valid,
  input  wire logic [2:0]  in_cur_cb_index,
  output dp_status_t       st,
  output logic             res_accepted,
  output logic             res_start_dma,
  output logic [2:0]       res_start_index,
  output logic [15:0]      res_avail_bytes
);

  logic [1:0]       status_r [BUF_COUNT];
  logic [1:0]       status_nxt [BUF_COUNT];
  logic [LEN_W-1:0] len_r [BUF_COUNT];
  logic [LEN_W-1:0] len_nxt [BUF_COUNT];
  logic [PTR_W-1:0] link_r [BUF_COUNT];
  logic [PTR_W-1:0] link_nxt [BUF_COUNT];
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt, ltail_r, ltail_nxt;
  logic [USED_W-1:0] used_r, used_nxt;

  logic [1:0]       req_r, req_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             active_r, active_nxt, end_r, end_nxt;
  logic             cvalid_r, cvalid_nxt;
  logic [2:0]       cidx_r, cidx_nxt;
  logic [PTR_W-1:0] cursor_r, cursor_nxt, cnt_r, cnt_nxt;
  logic             passed_r, passed_nxt, last_r, last_nxt;

  logic             acc_r, acc_nxt, start_r, start_nxt;
  logic [2:0]       sidx_r, sidx_nxt;
  logic [15:0]      avail_r, avail_nxt;
  logic             res_load;

  logic [PTR_W-1:0] first_empty;
  logic [PTR_W-1:0] cidx_ptr;

  logic                       ram_we;
  logic [$clog2(STORE_D)-1:0] ram_addr;

  assign cidx_ptr = PTR_W'(cidx_r);

  // Lowest empty buffer, or NIL when the pool is exhausted.
  always_comb begin
    first_empty = NIL;
    for (int i = BUF_COUNT - 1; i >= 0; i--) begin
      if (status_r[i] == ST_EMPTY) begin
        first_empty = PTR_W'(i);
      end
    end
  end

  always_comb begin
    logic [PTR_W-1:0]  f, d, h, t, lt;
    logic [IDX_W-1:0]  fi, di;
    logic [LEN_W-1:0]  l;
    logic [USED_W:0]   rem;
    f  = NIL;
    d  = NIL;
    h  = NIL;
    t  = NIL;
    lt = NIL;
    fi = '0;
    di = '0;
    l  = '0;
    rem = '0;
    for (int i = 0; i < BUF_COUNT; i++) begin
      status_nxt[i] = status_r[i];
      len_nxt[i]    = len_r[i];
      link_nxt[i]   = link_r[i];
    end
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    ltail_nxt  = ltail_r;
    used_nxt   = used_r;
    req_nxt    = req_r;
    byte_nxt   = byte_r;
    active_nxt = active_r;
    end_nxt    = end_r;
    cvalid_nxt = cvalid_r;
    cidx_nxt   = cidx_r;
    cursor_nxt = cursor_r;
    cnt_nxt    = cnt_r;
    passed_nxt = passed_r;
    last_nxt   = last_r;
    acc_nxt    = 1'b0;
    start_nxt  = 1'b0;
    sidx_nxt   = '0;
    res_load   = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = '0;

    case (cmd)
      DP_LATCH: begin
        req_nxt    = in_req_type;
        byte_nxt   = in_data_byte;
        active_nxt = in_dma_active;
        end_nxt    = in_dma_end;
        cvalid_nxt = in_cur_cb_valid;
        cidx_nxt   = in_cur_cb_index;
        cursor_nxt = head_r;
        cnt_nxt    = '0;
        passed_nxt = 1'b0;
        last_nxt   = 1'b0;
      end
      DP_PUSH: begin
        res_load = 1'b1;
        f = (fill_r != NIL) ? fill_r : first_empty;
        if (f != NIL) begin
          fi = f[IDX_W-1:0];
          l  = len_r[fi];
          if (fill_r == NIL) begin
            status_nxt[fi] = ST_FILLING;
            link_nxt[fi]   = NIL;
            fill_nxt       = f;
            l              = '0;
          end
          if (l < LEN_W'(DATA_SIZE)) begin
            ram_we   = 1'b1;
            ram_addr = $clog2(STORE_D)'(fi * DATA_SIZE) + $clog2(STORE_D)'(l);
            l        = l + 1'b1;
            used_nxt = used_r + 1'b1;
            acc_nxt  = 1'b1;
          end
          len_nxt[fi] = l;
          // A full buffer is sealed onto the queued chain at once.
          if (l >= LEN_W'(DATA_SIZE)) begin
            status_nxt[fi] = ST_QUEUED;
            link_nxt[fi]   = NIL;
            if (tail_r != NIL) begin
              link_nxt[tail_r[IDX_W-1:0]] = f;
            end else begin
              head_nxt = f;
            end
            tail_nxt = f;
            fill_nxt = NIL;
          end
        end
      end
      DP_POOL_RESET: begin
        res_load = 1'b1;
        for (int i = 0; i < BUF_COUNT; i++) begin
          status_nxt[i] = ST_EMPTY;
          len_nxt[i]    = '0;
          link_nxt[i]   = NIL;
        end
        status_nxt[0] = ST_FILLING;
        head_nxt      = NIL;
        tail_nxt      = NIL;
        ltail_nxt     = NIL;
        fill_nxt      = '0;
        used_nxt      = '0;
      end
      DP_NOP_RESULT: begin
        res_load = 1'b1;
      end
      DP_SEARCH: begin
        cursor_nxt = link_r[cursor_r[IDX_W-1:0]];
        cnt_nxt    = cnt_r + 1'b1;
      end
      DP_FREE_ACT, DP_FREE_END: begin
        d  = head_r;
        di = d[IDX_W-1:0];
        if (d == ltail_r) begin
          passed_nxt = 1'b1;
          last_nxt   = 1'b1;
        end
        head_nxt       = link_r[di];
        status_nxt[di] = ST_EMPTY;
        len_nxt[di]    = '0;
        link_nxt[di]   = NIL;
        used_nxt       = used_r - USED_W'(len_r[di]);
        cnt_nxt        = cnt_r + 1'b1;
      end
      DP_ACT_FIN: begin
        res_load = 1'b1;
        if (passed_r) begin
          ltail_nxt = head_r;
        end
        if (head_r == NIL) begin
          tail_nxt = NIL;
        end
      end
      DP_IDLE_FIN: begin
        res_load = 1'b1;
        h  = head_r;
        t  = tail_r;
        lt = ltail_r;
        if (end_r && (lt != NIL)) begin
          if (h == NIL) begin
            t = NIL;
          end
          lt = NIL;
        end
        // Seal a partially filled buffer before the restart.
        if ((fill_r != NIL) && (len_r[fill_r[IDX_W-1:0]] != '0)) begin
          fi             = fill_r[IDX_W-1:0];
          status_nxt[fi] = ST_QUEUED;
          link_nxt[fi]   = NIL;
          if (t != NIL) begin
            link_nxt[t[IDX_W-1:0]] = fill_r;
          end else begin
            h = fill_r;
          end
          t        = fill_r;
          fill_nxt = NIL;
        end
        if ((h != NIL) && (len_r[h[IDX_W-1:0]] != '0)) begin
          lt        = t;
          start_nxt = 1'b1;
          sidx_nxt  = h[2:0];
        end
        head_nxt  = h;
        tail_nxt  = t;
        ltail_nxt = lt;
      end
      default: begin
      end
    endcase

    rem = (USED_W + 1)'(CAP_BYTES) - (USED_W + 1)'(used_nxt);
    avail_nxt = (rem > (USED_W + 1)'(16'hFFFF)) ? 16'hFFFF : 16'(rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUF_COUNT; i++) begin
        status_r[i] <= ST_EMPTY;
        len_r[i]    <= '0;
        link_r[i]   <= NIL;
      end
      status_r[0] <= ST_FILLING;
      head_r      <= NIL;
      tail_r      <= NIL;
      ltail_r     <= NIL;
      fill_r      <= '0;
      used_r      <= '0;
    end else begin
      for (int i = 0; i < BUF_COUNT; i++) begin
        status_r[i] <= status_nxt[i];
        len_r[i]    <= len_nxt[i];
        link_r[i]   <= link_nxt[i];
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      ltail_r <= ltail_nxt;
      fill_r  <= fill_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    byte_r   <= byte_nxt;
    active_r <= active_nxt;
    end_r    <= end_nxt;
    cvalid_r <= cvalid_nxt;
    cidx_r   <= cidx_nxt;
    cursor_r <= cursor_nxt;
    cnt_r    <= cnt_nxt;
    passed_r <= passed_nxt;
    last_r   <= last_nxt;
    if (res_load) begin
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
      sidx_r  <= sidx_nxt;
      avail_r <= avail_nxt;
    end
  end

  assign st.req         = req_r;
  assign st.active      = active_r;
  assign st.found       = cvalid_r && (cursor_r == cidx_ptr);
  assign st.search_over = (cursor_r == NIL) || (cnt_r == PTR_W'(BUF_COUNT));
  assign st.act_done    = (head_r == NIL) || (head_r == cidx_ptr);
  assign st.end_cond    = end_r && (ltail_r != NIL);
  assign st.end_done    = (head_r == NIL) || last_r || (cnt_r == PTR_W'(BUF_COUNT));

  assign res_accepted    = acc_r;
  assign res_start_dma   = start_r;
  assign res_start_index = sidx_r;
  assign res_avail_bytes = avail_r;

  dbcm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_D)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (byte_r),
    .rd_addr (ram_addr),
    .rd_data ()
  );

endmodule

`default_nettype wire

[rtl/dbcm_checker.sv]
// ----------------------------------------------------------------------------
// dbcm_checker
// Port-level checks for the DMA buffer chain manager.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  a_no_stale: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result shown before transaction was processed");

  a_push_nostart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1])
    else $error("push result reported a DMA start");

  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:5] <= 16'd32768)
    else $error("free byte count above pool capacity");

endmodule

bind dma_buffer_chain_manager dbcm_checker u_dbcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[dv/dbcm_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcm_scoreboard
// Watches the request and result streams of the buffer chain manager, keeps
// its own model of the buffer pool, and compares every result transaction.
// ----------------------------------------------------------------------------
module dbcm_scoreboard
  import dbcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  // Same bit layout as out_tdata: accepted sits in the lowest bit.
  typedef struct packed {
    logic [15:0] avail_bytes;
    logic [2:0]  start_index;
    logic        start_dma;
    logic        accepted;
  } pool_result_t;

  logic [1:0]  status_q [BUF_COUNT];
  int unsigned length_q [BUF_COUNT];
  int unsigned link_q   [BUF_COUNT];
  int unsigned head, tail, fill, launched;
  pool_result_t results_due[$];

  function automatic void release_buf(int unsigned i);
    if (i >= BUF_COUNT) return;
    status_q[i] = ST_EMPTY;
    length_q[i] = 0;
    link_q[i]   = BUF_COUNT;
  endfunction

  function automatic int unsigned grab_buf();
    for (int unsigned i = 0; i < BUF_COUNT; i++)
      if (status_q[i] == ST_EMPTY) begin
        status_q[i] = ST_FILLING;
        length_q[i] = 0;
        link_q[i]   = BUF_COUNT;
        return i;
      end
    return BUF_COUNT;
  endfunction

  function automatic void clear_pool();
    for (int unsigned i = 0; i < BUF_COUNT; i++) release_buf(i);
    head = BUF_COUNT;
    tail = BUF_COUNT;
    launched = BUF_COUNT;
    fill = grab_buf();
  endfunction

  // Move a non-empty fill buffer onto the tail of the queued chain.
  function automatic void seal_fill_buf();
    if (fill >= BUF_COUNT || length_q[fill] == 0) return;
    status_q[fill] = ST_QUEUED;
    link_q[fill] = BUF_COUNT;
    if (tail < BUF_COUNT) link_q[tail] = fill;
    else head = fill;
    tail = fill;
    fill = BUF_COUNT;
  endfunction

  function automatic bit in_chain(int unsigned idx);
    int unsigned c;
    c = head;
    for (int n = 0; n < BUF_COUNT && c < BUF_COUNT; n++) begin
      if (c == idx) return 1;
      c = link_q[c];
    end
    return 0;
  endfunction

  function automatic logic [15:0] free_bytes();
    int unsigned used, cap;
    used = 0;
    cap = CAP_BYTES;
    for (int i = 0; i < BUF_COUNT; i++)
      if (status_q[i] != ST_EMPTY) used += length_q[i];
    if (used >= cap) return 0;
    cap -= used;
    return cap > 16'hFFFF ? 16'hFFFF : cap[15:0];
  endfunction

  function automatic pool_result_t apply_request(logic [1:0] req, logic [15:0] d);
    pool_result_t r;
    int unsigned cidx, dsc;
    bit passed, last;
    r = '0;
    cidx = d[13:11];
    case (req)
      REQ_PUSH: begin
        if (fill >= BUF_COUNT) fill = grab_buf();
        if (fill < BUF_COUNT) begin
          if (length_q[fill] < DATA_SIZE) begin
            length_q[fill]++;
            r.accepted = 1'b1;
          end
          if (length_q[fill] >= DATA_SIZE) seal_fill_buf();
        end
      end
      REQ_FLUSH: begin
        if (d[8]) begin
          // DMA running: free everything ahead of the current descriptor.
          if (d[10] && in_chain(cidx)) begin
            passed = 0;
            for (int n = 0; n < BUF_COUNT && head < BUF_COUNT && head != cidx; n++) begin
              dsc = head;
              if (dsc == launched) passed = 1;
              head = link_q[dsc];
              release_buf(dsc);
            end
            if (passed) launched = head;
            if (head >= BUF_COUNT) tail = BUF_COUNT;
          end
        end else begin
          if (d[9] && launched < BUF_COUNT) begin
            for (int n = 0; n < BUF_COUNT && head < BUF_COUNT; n++) begin
              dsc = head;
              last = (dsc == launched);
              head = link_q[dsc];
              release_buf(dsc);
              if (last) break;
            end
            if (head >= BUF_COUNT) tail = BUF_COUNT;
            launched = BUF_COUNT;
          end
          seal_fill_buf();
          if (head < BUF_COUNT && length_q[head] > 0) begin
            launched = tail;
            r.start_dma = 1'b1;
            r.start_index = head[2:0];
          end
        end
      end
      REQ_RESET: clear_pool();
      default: ;
    endcase
    r.avail_bytes = free_bytes();
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t got, want;
    if (!rst_n) begin
      clear_pool();
      results_due.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_tvalid && in_tready)
        results_due.push_back(apply_request(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[20:0];
        if (results_due.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count <= fail_count + 1;
          end
          if (got.start_dma !== want.start_dma) begin
            $error("start_dma: expected %0d, got %0d", want.start_dma, got.start_dma);
            fail_count <= fail_count + 1;
          end
          if (got.start_index !== want.start_index) begin
            $error("start_index: expected %0d, got %0d", want.start_index,
                   got.start_index);
            fail_count <= fail_count + 1;
          end
          if (got.avail_bytes !== want.avail_bytes) begin
            $error("avail_bytes: expected %0d, got %0d", want.avail_bytes,
                   got.avail_bytes);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= results_due.size();
    end
  end

endmodule

[dv/dma_buffer_chain_manager_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_buffer_chain_manager_tb
// Drives push, flush, reset and unknown requests into the buffer chain manager with
// random gaps and output stalls; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module dma_buffer_chain_manager_tb;
  import dbcm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          sent = 0;
  bit          stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dma_buffer_chain_manager uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  dbcm_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Timeout watchdog. About 1200 transactions fit well inside the limit even
  // with the longest gaps, stalls and chain walks, so the limit is generous.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall before each result, with stall-free stretches.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (cycle_count % 20000 < 4000) stall = 0;
      repeat (stall) @(posedge clk);
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      out_tready <= 1'b0;
    end
  end

  // One request transaction; the gap before it is drawn per item. Valid
  // stays high across back-to-back transactions and drops only for a gap.
  task automatic send_req(logic [1:0] req, logic [15:0] d, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= d;
    @(posedge clk iff in_tready);
    sent++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic pause_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic logic [15:0] flush_word(bit act, bit fin, bit cv, logic [2:0] ci);
    return {2'b00, ci, cv, fin, act, 8'($urandom)};
  endfunction

  function automatic int draw_gap();
    return (cycle_count % 20000 < 4000) ? 0 : $urandom_range(0, 13);
  endfunction

  // Short push bursts; with quick set there are no gaps between the bytes.
  task automatic push_run(int n, bit quick);
    for (int i = 0; i < n; i++)
      send_req(REQ_PUSH, {8'h00, 8'($urandom)}, quick ? 0 : draw_gap());
  endtask

  initial begin
    int kind;
    bit drained;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of the fields and every request kind.
    send_req(REQ_PUSH, 16'h00FF, 0);
    send_req(REQ_PUSH, 16'h0000, 3);
    send_req(2'd3, 16'hFFFF, 0);
    send_req(REQ_FLUSH, flush_word(1, 1, 1, 3'd7), 1);   // descriptor not queued
    send_req(REQ_FLUSH, flush_word(0, 0, 0, 3'd0), 0);   // seal and start
    send_req(REQ_PUSH, 16'hC0A5, 0);
    send_req(REQ_FLUSH, flush_word(1, 0, 0, 3'd1), 0);   // invalid descriptor
    send_req(REQ_FLUSH, flush_word(1, 0, 1, 3'd0), 0);
    send_req(REQ_FLUSH, flush_word(0, 1, 0, 3'd0), 2);   // launch ends
    send_req(REQ_FLUSH, flush_word(0, 0, 1, 3'd5), 0);   // idle without end
    send_req(REQ_RESET, 16'hFFFF, 0);
    send_req(REQ_FLUSH, flush_word(0, 1, 1, 3'd0), 0);

    // Build a chain of several buffers, then walk it from both flush sides.
    push_run(40, 1);
    send_req(REQ_FLUSH, flush_word(0, 0, 0, 3'd0), 0);
    push_run(30, 1);
    send_req(REQ_FLUSH, flush_word(0, 0, 0, 3'd0), 0);
    push_run(20, 1);
    send_req(REQ_FLUSH, flush_word(0, 0, 0, 3'd0), 0);
    send_req(REQ_FLUSH, flush_word(1, 0, 1, 3'd2), 0);   // frees ahead of 2
    send_req(REQ_FLUSH, flush_word(0, 1, 0, 3'd0), 0);
    send_req(REQ_RESET, 16'h0000, 0);

    // Let the block drain before the random part.
    pause_drain();

    // Random part: mostly pushes with realistic flush traffic.
    while (sent < 1200) begin
      kind = $urandom_range(0, 99);
      if (!drained && sent >= 600) begin
        pause_drain();
        drained = 1'b1;
      end
      if (kind < 2)
        send_req(REQ_RESET, 16'($urandom), draw_gap());
      else if (kind < 3)
        send_req(2'd3, 16'($urandom), draw_gap());
      else if (kind < 5)
        push_run($urandom_range(5, 30), 1);
      else if (kind < 25)
        send_req(REQ_FLUSH, flush_word($urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 5) != 0, 3'($urandom)), draw_gap());
      else
        send_req(REQ_PUSH, {8'($urandom), 8'($urandom)}, draw_gap());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
